// File: src/linear_probe_hash_table_macros.svh
// assertion macros shared by the hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lpht_pkg.sv
// types and constants of the linear probing hash table
package lpht_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int KEY_W      = 31;
	localparam int PAY_W      = 32;
	localparam int IDX_W      = 10;

	typedef enum logic [1:0] {
		KIND_SEARCH = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_USED  = 2'd1,
		SLOT_GONE  = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		RES_OK   = 2'd0,
		RES_MISS = 2'd1,
		RES_FULL = 2'd2
	} res_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} state_t;

	typedef struct packed {
		slot_state_t           st;
		logic [KEY_W-1:0]      key;
		logic [PAY_W-1:0]      pay;
	} entry_t;

endpackage

// File: src/linear_probe_hash_table.sv
// linear probing hash table: 1024 slots, one probe per cycle over a single-port-read memory
// a hit on the home slot passes the slot read register, then the result register, after accept
// one item at a time: a new item is taken only in idle, once the last item's probes are done
// reset: a clearing pass over all 1024 slots marks every slot empty, no item is taken meanwhile
// the output register holds a finished result while a new item is taken
module linear_probe_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [30:0] key,
	input  logic [31:0] payload,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_payload,
	output logic [9:0]  slot_index
);

	// slot memory: status, key and payload of each slot in one word
	lpht_pkg::entry_t mem_q [lpht_pkg::TABLE_SIZE];
	lpht_pkg::entry_t rd_q;

	// sequencer state
	lpht_pkg::state_t             state_q, state_d;
	logic [lpht_pkg::SLOT_W-1:0]  clr_q, clr_d;
	logic [lpht_pkg::SLOT_W-1:0]  slot_q, slot_d;
	logic [lpht_pkg::SLOT_W-1:0]  cnt_q, cnt_d;

	// the item at work
	lpht_pkg::kind_t              kind_q;
	logic [lpht_pkg::KEY_W-1:0]   key_q;
	logic [lpht_pkg::PAY_W-1:0]   pay_q;

	// result register
	logic                         out_valid_q;
	lpht_pkg::res_t               res_q, res_d;
	logic [lpht_pkg::PAY_W-1:0]   fp_q, fp_d;
	logic [lpht_pkg::IDX_W-1:0]   idx_q, idx_d;

	// memory port controls
	logic [lpht_pkg::SLOT_W-1:0]  rd_addr;
	logic                         wr_en;
	logic [lpht_pkg::SLOT_W-1:0]  wr_addr;
	lpht_pkg::entry_t             wr_data;

	logic                         accept;
	logic                         done;
	logic                         out_free;
	logic                         hit;
	logic                         last;
	logic [lpht_pkg::SLOT_W-1:0]  next_slot;
	logic [lpht_pkg::SLOT_W-1:0]  home;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// home slot is key modulo the table size, a mask for a power of two
	assign home = lpht_pkg::SLOT_W'(key % lpht_pkg::TABLE_SIZE);

	// probe wraps from the last slot back to slot 0
	assign next_slot = (slot_q == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1)) ?
		'0 : slot_q + 1'b1;

	// the shared compare: does the slot just read hold the key
	assign hit  = (rd_q.st == lpht_pkg::SLOT_USED) && (rd_q.key == key_q);
	// this probe is the last one allowed
	assign last = (cnt_q == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1));

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::ST_CLEAR;
			clr_q   <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			slot_q  <= slot_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state, memory port and result
	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		slot_d  = slot_q;
		cnt_d   = cnt_q;
		rd_addr = home;
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '{st: lpht_pkg::SLOT_EMPTY, key: key_q, pay: pay_q};
		done    = 1'b0;
		res_d   = lpht_pkg::RES_MISS;
		fp_d    = '0;
		idx_d   = '0;
		in_stall = 1'b1;

		unique case (state_q)
			lpht_pkg::ST_CLEAR: begin
				// sweep one slot a cycle to empty
				wr_en = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1)) begin
					state_d = lpht_pkg::ST_IDLE;
				end
			end
			lpht_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				// home slot read launches with the accepting beat
				if (in_valid) begin
					state_d = lpht_pkg::ST_PROBE;
					slot_d  = home;
					cnt_d   = '0;
				end
			end
			lpht_pkg::ST_PROBE: begin
				case (kind_q) inside
					lpht_pkg::KIND_SEARCH, lpht_pkg::KIND_DELETE: begin
						if (rd_q.st == lpht_pkg::SLOT_EMPTY) begin
							done = 1'b1;
						end else if (hit) begin
							done  = 1'b1;
							res_d = lpht_pkg::RES_OK;
							fp_d  = rd_q.pay;
							idx_d = lpht_pkg::IDX_W'(slot_q);
							if (kind_q == lpht_pkg::KIND_DELETE) begin
								wr_en   = 1'b1;
								wr_data = '{st: lpht_pkg::SLOT_GONE, key: rd_q.key,
									pay: rd_q.pay};
							end
						end else if (last) begin
							done = 1'b1;
						end
					end
					lpht_pkg::KIND_INSERT: begin
						// first empty or deleted slot takes the entry
						if (rd_q.st != lpht_pkg::SLOT_USED) begin
							done    = 1'b1;
							res_d   = lpht_pkg::RES_OK;
							idx_d   = lpht_pkg::IDX_W'(slot_q);
							wr_en   = 1'b1;
							wr_data = '{st: lpht_pkg::SLOT_USED, key: key_q, pay: pay_q};
						end else if (last) begin
							done  = 1'b1;
							res_d = lpht_pkg::RES_FULL;
						end
					end
					default: begin
						// unused kind: no change, key not found
						done = 1'b1;
					end
				endcase

				wr_addr = slot_q;
				if (done) begin
					if (out_free) begin
						state_d = lpht_pkg::ST_IDLE;
					end else begin
						// result register busy: hold and re-read this slot
						wr_en = 1'b0;
					end
					rd_addr = slot_q;
				end else begin
					slot_d  = next_slot;
					cnt_d   = cnt_q + 1'b1;
					rd_addr = next_slot;
				end
			end
			default: begin
				state_d = lpht_pkg::ST_CLEAR;
			end
		endcase
	end

	// slot memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// item fields, captured on the accepting beat
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= lpht_pkg::kind_t'(kind);
			key_q  <= key;
			pay_q  <= payload;
		end
	end

	// result beat handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lpht_pkg::ST_PROBE && done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result fields load only when a beat is finished
	always_ff @(posedge clk) begin
		if (state_q == lpht_pkg::ST_PROBE && done && out_free) begin
			res_q <= res_d;
			fp_q  <= fp_d;
			idx_q <= idx_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q;
	assign found_payload = fp_q;
	assign slot_index    = idx_q;

endmodule

// File: src/lpht_checker.sv
// port-level checks of the linear probing hash table
`include "linear_probe_hash_table_macros.svh"

module lpht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic [30:0] key,
	input logic [31:0] payload,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] found_payload,
	input logic [9:0]  slot_index
);

	// a stalled result beat holds
	`LPHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(found_payload) && $stable(slot_index), "stalled result changed")

	// only defined status codes leave the block
	`LPHT_ASSERT_NOW(a_status_code, out_valid, status == lpht_pkg::RES_OK || status == lpht_pkg::RES_MISS || status == lpht_pkg::RES_FULL, "undefined status code")

	// a failed operation reports zero payload and slot
	`LPHT_ASSERT_NOW(a_fail_zero, out_valid && status != lpht_pkg::RES_OK, found_payload == '0 && slot_index == '0, "failure carries data")

	// the block is busy right after taking an item
	`LPHT_ASSERT_NEXT(a_busy_after, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

// File: tb/tb.sv
// self-checking testbench of the linear probing hash table, with a shadow slot table
module tb;

	// the port allows a fourth operation code; the block must ignore it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int LONG_HOLD   = 600;         // cycles the receiver sits on its stall line once
	localparam int TAIL_CYCLES = 1100;        // a full-table probe plus margin
	localparam int RUN_LIMIT   = 40_000_000;  // time units, the hard stop of the run
	localparam int MAX_SHOWN   = 10;

	// one answer as the block should give it
	typedef struct packed {
		lpht_pkg::res_t             status;
		logic [lpht_pkg::PAY_W-1:0] pay;
		logic [lpht_pkg::IDX_W-1:0] idx;
	} answer_t;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// shadow copy of the slot table plus the queue of answers still owed by the block
	class probe_table_predictor;
		lpht_pkg::slot_state_t      slot_st[lpht_pkg::TABLE_SIZE];
		logic [lpht_pkg::KEY_W-1:0] slot_key[lpht_pkg::TABLE_SIZE];
		logic [lpht_pkg::PAY_W-1:0] slot_pay[lpht_pkg::TABLE_SIZE];
		answer_t                    due_answers[$];
		int                         mismatches;

		function new();
			foreach (slot_st[i]) begin
				slot_st[i]  = lpht_pkg::SLOT_EMPTY;
				slot_key[i] = '0;
				slot_pay[i] = '0;
			end
			mismatches = 0;
		endfunction

		// walk from the home slot: tombstones are stepped over, an empty slot ends the walk
		function bit find_key(logic [lpht_pkg::KEY_W-1:0] k, output int where);
			int s;
			s = int'(k % lpht_pkg::TABLE_SIZE);
			where = 0;
			for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
				if (slot_st[s] == lpht_pkg::SLOT_EMPTY)
					return 1'b0;
				if (slot_st[s] == lpht_pkg::SLOT_USED && slot_key[s] == k) begin
					where = s;
					return 1'b1;
				end
				s = (s + 1) % lpht_pkg::TABLE_SIZE;
			end
			return 1'b0;
		endfunction

		// applies one operation to the shadow table and returns the answer it owes
		function answer_t apply_op(logic [1:0] op, logic [lpht_pkg::KEY_W-1:0] k,
				logic [lpht_pkg::PAY_W-1:0] p);
			answer_t a;
			int      s;
			int      where;
			a.status = lpht_pkg::RES_MISS;
			a.pay    = '0;
			a.idx    = '0;
			case (op)
				lpht_pkg::KIND_SEARCH: begin
					if (find_key(k, where)) begin
						a.status = lpht_pkg::RES_OK;
						a.pay    = slot_pay[where];
						a.idx    = lpht_pkg::IDX_W'(where);
					end
				end
				lpht_pkg::KIND_DELETE: begin
					if (find_key(k, where)) begin
						a.status       = lpht_pkg::RES_OK;
						a.pay          = slot_pay[where];
						a.idx          = lpht_pkg::IDX_W'(where);
						slot_st[where] = lpht_pkg::SLOT_GONE;
					end
				end
				lpht_pkg::KIND_INSERT: begin
					// first empty or deleted slot wins, duplicates are not looked for
					a.status = lpht_pkg::RES_FULL;
					s = int'(k % lpht_pkg::TABLE_SIZE);
					for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
						if (slot_st[s] != lpht_pkg::SLOT_USED) begin
							slot_st[s]  = lpht_pkg::SLOT_USED;
							slot_key[s] = k;
							slot_pay[s] = p;
							a.status    = lpht_pkg::RES_OK;
							a.idx       = lpht_pkg::IDX_W'(s);
							break;
						end
						s = (s + 1) % lpht_pkg::TABLE_SIZE;
					end
				end
				default: ;
			endcase
			return a;
		endfunction

		function void note_beat(logic [1:0] op, logic [lpht_pkg::KEY_W-1:0] k,
				logic [lpht_pkg::PAY_W-1:0] p);
			due_answers.push_back(apply_op(op, k, p));
		endfunction

		function void check_beat(logic [1:0] st, logic [lpht_pkg::PAY_W-1:0] fp,
				logic [lpht_pkg::IDX_W-1:0] idx);
			answer_t a;
			if (due_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result beat: status %0d payload %h slot %0d",
						st, fp, idx);
				return;
			end
			a = due_answers.pop_front();
			if (st !== a.status || fp !== a.pay || idx !== a.idx) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display({"result mismatch: expected status %0d payload %h slot %0d,",
						" got status %0d payload %h slot %0d"},
						a.status, a.pay, a.idx, st, fp, idx);
			end
		endfunction

		function int pending();
			return due_answers.size();
		endfunction

		function int free_slots();
			int count;
			count = 0;
			foreach (slot_st[i])
				if (slot_st[i] != lpht_pkg::SLOT_USED)
					count++;
			return count;
		endfunction

		// picks the key of a random occupied slot, so searches and deletes can hit
		function bit pick_live(output logic [lpht_pkg::KEY_W-1:0] k);
			int used[$];
			k = '0;
			foreach (slot_st[i])
				if (slot_st[i] == lpht_pkg::SLOT_USED)
					used.push_back(i);
			if (used.size() == 0)
				return 1'b0;
			k = slot_key[used[$urandom_range(0, used.size() - 1)]];
			return 1'b1;
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 kind;
	logic [lpht_pkg::KEY_W-1:0] key;
	logic [lpht_pkg::PAY_W-1:0] payload;
	logic                       out_valid;
	logic                       out_stall;
	logic [1:0]                 status;
	logic [lpht_pkg::PAY_W-1:0] found_payload;
	logic [lpht_pkg::IDX_W-1:0] slot_index;

	probe_table_predictor shadow;
	int                   burst_left;
	bit                   hold_req;

	linear_probe_hash_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.key           (key),
		.payload       (payload),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_payload (found_payload),
		.slot_index    (slot_index)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// called at a falling edge; returns at a falling edge with valid still high unless
	// a gap was taken, so the caller must send again or drain right away
	task automatic send_beat(input logic [1:0] op, input logic [lpht_pkg::KEY_W-1:0] k,
			input logic [lpht_pkg::PAY_W-1:0] p);
		int gap;
		in_valid <= 1'b1;
		kind     <= op;
		key      <= k;
		payload  <= p;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		shadow.note_beat(op, k, p);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				// steady stretch with valid held high
				burst_left = $urandom_range(40, 120);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 15);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// drop valid and wait until every owed answer has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (shadow.pending() != 0)
			@(negedge clk);
	endtask

	// random key whose home slot falls in a window of spread slots from base
	function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key(int base, int spread);
		logic [lpht_pkg::KEY_W-1:0] k;
		k = lpht_pkg::KEY_W'($urandom);
		k[lpht_pkg::SLOT_W-1:0] = lpht_pkg::SLOT_W'((base + $urandom_range(0, spread - 1))
			% lpht_pkg::TABLE_SIZE);
		return k;
	endfunction

	// mixed traffic: live keys for most searches and deletes, fresh keys for misses,
	// a few duplicate inserts and a few beats of the unused operation
	task automatic mixed_phase(int beats, int base, int spread);
		int                         r;
		bit                         have;
		logic [lpht_pkg::KEY_W-1:0] k;
		logic [lpht_pkg::KEY_W-1:0] live;
		repeat (beats) begin
			r = $urandom_range(0, 99);
			have = shadow.pick_live(live);
			k = fresh_key(base, spread);
			if (r < 40) begin
				if (r < 6 && have)
					k = live;
				send_beat(lpht_pkg::KIND_INSERT, k, $urandom);
			end else if (r < 95) begin
				if (have && $urandom_range(0, 3) != 0)
					k = live;
				send_beat(r < 70 ? lpht_pkg::KIND_SEARCH : lpht_pkg::KIND_DELETE, k,
					$urandom);
			end else begin
				send_beat(KIND_UNUSED, lpht_pkg::KEY_W'($urandom), $urandom);
			end
		end
	endtask

	// result side: stall patterns of varying density, and one long hold-off on request
	initial begin
		stall_mode_t mode;
		int          span;
		int          tick;
		out_stall = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				// long enough for the block to fill and push back on its input
				repeat (LONG_HOLD) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				hold_req = 1'b0;
			end
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
					default:     out_stall <= (tick % 4 == 0);
				endcase
			end
		end
	end

	// every result beat is checked against the oldest owed answer
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			shadow.check_beat(status, found_payload, slot_index);
	end

	// hard stop in case the block hangs
	initial begin
		#RUN_LIMIT;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int                         base;
		int                         free_n;
		logic [lpht_pkg::KEY_W-1:0] k;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = lpht_pkg::KIND_SEARCH;
		key        = '0;
		payload    = '0;
		hold_req   = 1'b0;
		burst_left = 1;
		shadow     = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the block clears its slot table first and holds in_stall meanwhile

		// directed: extremes, wrap-around, duplicates, tombstones, misses
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_0000, 32'h0000_0000);  // empty home slot
		send_beat(lpht_pkg::KIND_INSERT, 31'h0000_0000, 32'h0000_0000);  // slot 0
		send_beat(lpht_pkg::KIND_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);  // slot 1023
		send_beat(lpht_pkg::KIND_SEARCH, 31'h7FFF_FFFF, 32'h0000_0000);
		send_beat(lpht_pkg::KIND_INSERT, 31'h0000_03FF, 32'hA5A5_A5A5);  // wraps past 1023, 0
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_03FF, 32'h0000_0000);
		send_beat(lpht_pkg::KIND_INSERT, 31'h0000_0400, 32'h0000_0001);  // home 0, lands on 2
		send_beat(lpht_pkg::KIND_INSERT, 31'h0000_0000, 32'h0000_0002);  // duplicate key
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_0000, 32'h0000_0000);  // finds first copy
		send_beat(lpht_pkg::KIND_DELETE, 31'h0000_0000, 32'hFFFF_FFFF);
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_0000, 32'h0000_0000);  // over the tombstone
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_0400, 32'h0000_0000);
		send_beat(lpht_pkg::KIND_DELETE, 31'h7FFF_FFFF, 32'h0000_0000);
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_03FF, 32'h0000_0000);  // two tombstones
		send_beat(lpht_pkg::KIND_INSERT, 31'h7FFF_FC00, 32'h5A5A_5A5A);  // reuses slot 0
		send_beat(lpht_pkg::KIND_DELETE, 31'h5555_5400, 32'h0000_0000);  // delete miss
		send_beat(lpht_pkg::KIND_SEARCH, 31'h2AAA_AAAA, 32'h0000_0000);
		send_beat(KIND_UNUSED, 31'h0000_0000, 32'hFFFF_FFFF);            // changes nothing
		send_beat(lpht_pkg::KIND_SEARCH, 31'h0000_0000, 32'h0000_0000);
		send_beat(lpht_pkg::KIND_DELETE, 31'h0000_0000, 32'h0000_0000);
		send_beat(lpht_pkg::KIND_DELETE, 31'h0000_0000, 32'h0000_0000);  // already gone
		send_beat(lpht_pkg::KIND_INSERT, 31'h2AAA_AAAA, 32'h1234_5678);

		// clustered traffic around the top of the table so probes wrap;
		// the receiver holds off early on while beats keep coming
		hold_req = 1'b1;
		base = $urandom_range(980, 1010);
		mixed_phase(350, base, 48);

		// sender pause until every answer is back, so the free count is exact
		drain();
		free_n = shadow.free_slots();

		// fill every free slot, then a few inserts into the full table
		for (int i = 0; i < free_n + 6; i++) begin
			k = lpht_pkg::KEY_W'($urandom);
			k[lpht_pkg::SLOT_W-1:0] = lpht_pkg::SLOT_W'(i % lpht_pkg::TABLE_SIZE);
			send_beat(lpht_pkg::KIND_INSERT, k, $urandom);
		end

		// no empty slot is left: misses run the whole table, deletes open tombstones
		mixed_phase(80, 0, lpht_pkg::TABLE_SIZE);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: linear_probe_hash_table.f
+incdir+src
src/lpht_pkg.sv
src/linear_probe_hash_table.sv
src/lpht_checker.sv
tb/tb.sv
